/* hw/rtl/field_statistics_reducer_core_macros.svh */
// Assertion macros used by the checker file of the field statistics reducer.
`ifndef FIELD_STATISTICS_REDUCER_CORE_MACROS_SVH
`define FIELD_STATISTICS_REDUCER_CORE_MACROS_SVH

// The antecedent must be followed by the consequent in the next cycle.
`define FSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fsr: next-cycle check failed");

// The antecedent must come with the consequent in the same cycle.
`define FSR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fsr: same-cycle check failed");

`endif

/* hw/rtl/fsr_pkg.sv */
// Package with constants, record types and state codes of the field statistics reducer.
`timescale 1ns / 1ps
package fsr_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int MAX_COUNT    = 65536;

  localparam int DATA_W = 24;
  localparam int SUM_W  = 41;
  localparam int SQ_W   = 63;
  localparam int PROD_W = 2 * DATA_W;
  localparam int CNT_W  = 17;
  localparam int ROOT_W = 32;
  localparam int RAD_W  = 2 * ROOT_W;

  localparam int SAMPLE_SHIFT = DATA_W - SAMPLE_WIDTH;
  localparam logic signed [DATA_W-1:0] LOW_INIT  = DATA_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [DATA_W-1:0] HIGH_INIT = DATA_W'(-(1 << (SAMPLE_WIDTH - 1)));

  localparam int QDEPTH = 2;
  localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int LVL_W  = $clog2(QDEPTH + 1);

  localparam int DIV_STEPS  = SUM_W;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic signed [DATA_W-1:0] low;
    logic signed [DATA_W-1:0] high;
    logic signed [SUM_W-1:0]  sum;
    logic [SQ_W-1:0]          sq_total;
    logic [CNT_W-1:0]         count;
    logic                     ovf;
  } fsr_stats_t;

  typedef struct packed {
    logic       valid;
    fsr_stats_t stats;
  } fsr_push_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DONE
  } fsr_back_state_t;

endpackage

/* hw/rtl/fsr_if.sv */
// Valid/ready channel interfaces for samples and field results.
`timescale 1ns / 1ps
interface fsr_in_if
  import fsr_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample;
  logic                     last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

interface fsr_out_if
  import fsr_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] minimum;
  logic signed [DATA_W-1:0] maximum;
  logic signed [DATA_W-1:0] mean;
  logic [ROOT_W-1:0]        root_sum_squares;
  logic [CNT_W-1:0]         item_count;
  logic                     overflow;

  modport source (output valid, output minimum, output maximum, output mean,
                  output root_sum_squares, output item_count, output overflow,
                  input ready);
  modport sink (input valid, input minimum, input maximum, input mean,
                input root_sum_squares, input item_count, input overflow,
                output ready);
endinterface

/* hw/rtl/fsr_front.sv */
// Front end: takes samples, squares them and keeps the running field statistics.
`timescale 1ns / 1ps
module fsr_front
  import fsr_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  fsr_in_if.sink          in_req,
  input  logic [LVL_W-1:0] q_level,
  output fsr_push_t       push
);

  logic                     stg_valid_r;
  logic signed [DATA_W-1:0] stg_sample_r;
  logic [PROD_W-1:0]        stg_sq_r;
  logic                     stg_last_r;

  logic signed [DATA_W-1:0] low_r, low_nxt;
  logic signed [DATA_W-1:0] high_r, high_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SQ_W-1:0]          sq_total_r, sq_total_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     ovf_r, ovf_nxt;

  logic signed [DATA_W-1:0] shifted;
  logic signed [DATA_W-1:0] s_in;
  logic signed [PROD_W-1:0] prod;
  logic                     full;
  logic                     pending;
  logic                     accept;

  // Drop the bits above SAMPLE_WIDTH and sign-extend from there.
  assign shifted = in_req.sample <<< SAMPLE_SHIFT;
  assign s_in    = shifted >>> SAMPLE_SHIFT;
  assign prod    = s_in * s_in;

  // A field end still in the stage will take a queue slot next cycle.
  assign pending      = stg_valid_r & stg_last_r;
  assign in_req.ready = ({1'b0, q_level} + (LVL_W + 1)'(pending)) < (LVL_W + 1)'(QDEPTH);
  assign accept       = in_req.valid & in_req.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= accept;
    end
    if (accept) begin
      stg_sample_r <= s_in;
      stg_sq_r     <= PROD_W'(prod);
      stg_last_r   <= in_req.last;
    end
  end

  assign full = count_r >= CNT_W'(MAX_COUNT);

  always_comb begin
    low_nxt      = low_r;
    high_nxt     = high_r;
    sum_nxt      = sum_r;
    sq_total_nxt = sq_total_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    if (full) begin
      ovf_nxt = 1'b1;
    end else begin
      if (stg_sample_r < low_r) low_nxt = stg_sample_r;
      if (stg_sample_r > high_r) high_nxt = stg_sample_r;
      sum_nxt      = sum_r + {{(SUM_W - DATA_W){stg_sample_r[DATA_W-1]}}, stg_sample_r};
      sq_total_nxt = sq_total_r + {{(SQ_W - PROD_W){1'b0}}, stg_sq_r};
      count_nxt    = count_r + CNT_W'(1);
    end
  end

  always_comb begin
    push.valid          = pending;
    push.stats.low      = low_nxt;
    push.stats.high     = high_nxt;
    push.stats.sum      = sum_nxt;
    push.stats.sq_total = sq_total_nxt;
    push.stats.count    = count_nxt;
    push.stats.ovf      = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || pending) begin
      low_r      <= LOW_INIT;
      high_r     <= HIGH_INIT;
      sum_r      <= '0;
      sq_total_r <= '0;
      count_r    <= '0;
      ovf_r      <= 1'b0;
    end else if (stg_valid_r) begin
      low_r      <= low_nxt;
      high_r     <= high_nxt;
      sum_r      <= sum_nxt;
      sq_total_r <= sq_total_nxt;
      count_r    <= count_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

endmodule

/* hw/rtl/fsr_queue.sv */
// Short queue of finished field records between the front and the back end.
`timescale 1ns / 1ps
module fsr_queue
  import fsr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  fsr_push_t        push,
  input  logic             pop,
  output logic             q_valid,
  output fsr_stats_t       q_data,
  output logic [LVL_W-1:0] q_level
);

  fsr_stats_t       mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [LVL_W-1:0] level_r;
  logic             do_pop;

  assign q_valid = level_r != '0;
  assign q_data  = mem[rd_ptr_r];
  assign q_level = level_r;
  assign do_pop  = pop & q_valid;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr_r] <= push.stats;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push.valid && !do_pop) begin
        level_r <= level_r + LVL_W'(1);
      end else if (!push.valid && do_pop) begin
        level_r <= level_r - LVL_W'(1);
      end
    end
  end

endmodule

/* hw/rtl/fsr_back.sv */
// Back end: bit-serial divide for the mean, bit-pair square root, result register.
`timescale 1ns / 1ps
module fsr_back
  import fsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  fsr_stats_t q_data,
  output logic       pop,
  fsr_out_if.source  out_res
);

  fsr_back_state_t state_r, state_nxt;

  logic [STEP_W-1:0]        step_r;
  logic [SUM_W-1:0]         dvd_r;
  logic [CNT_W-1:0]         rem_r;
  logic [CNT_W-1:0]         div_r;
  logic                     neg_r;
  logic [RAD_W-1:0]         rad_r;
  logic [ROOT_W:0]          srem_r;
  logic [ROOT_W-1:0]        root_r;
  logic signed [DATA_W-1:0] low_r;
  logic signed [DATA_W-1:0] high_r;
  logic [CNT_W-1:0]         count_r;
  logic                     ovf_r;

  logic [CNT_W:0]    rem_shift;
  logic              q_bit;
  logic [ROOT_W+2:0] srem_shift;
  logic [ROOT_W+2:0] trial;
  logic              r_bit;
  logic [SUM_W-1:0]  mean_full;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (q_valid) state_nxt = BK_RUN;
      BK_RUN:  if (step_r == '0) state_nxt = BK_DONE;
      BK_DONE: if (out_res.ready) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop           = 1'b0;
    out_res.valid = 1'b0;
    case (state_r)
      BK_IDLE: pop = q_valid;
      BK_RUN:  pop = 1'b0;
      BK_DONE: out_res.valid = 1'b1;
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // One quotient bit per cycle from the magnitude of the sum.
  assign rem_shift = {rem_r, dvd_r[SUM_W-1]};
  assign q_bit     = rem_shift >= {1'b0, div_r};

  // One root bit per cycle in the last ROOT_STEPS steps of the run, from the next two radicand bits.
  assign srem_shift = {srem_r, rad_r[RAD_W-1 -: 2]};
  assign trial      = {1'b0, root_r, 2'b01};
  assign r_bit      = srem_shift >= trial;

  always_ff @(posedge clk) begin
    if (state_r == BK_IDLE && q_valid) begin
      dvd_r   <= q_data.sum[SUM_W-1] ? SUM_W'(-q_data.sum) : SUM_W'(q_data.sum);
      neg_r   <= q_data.sum[SUM_W-1];
      div_r   <= (q_data.count == '0) ? CNT_W'(1) : q_data.count;
      rem_r   <= '0;
      rad_r   <= {{(RAD_W - SQ_W){1'b0}}, q_data.sq_total};
      srem_r  <= '0;
      root_r  <= '0;
      step_r  <= STEP_W'(DIV_STEPS - 1);
      low_r   <= q_data.low;
      high_r  <= q_data.high;
      count_r <= q_data.count;
      ovf_r   <= q_data.ovf;
    end else if (state_r == BK_RUN) begin
      dvd_r <= {dvd_r[SUM_W-2:0], q_bit};
      rem_r <= q_bit ? CNT_W'(rem_shift - {1'b0, div_r}) : CNT_W'(rem_shift);
      if (step_r < STEP_W'(ROOT_STEPS)) begin
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        srem_r <= r_bit ? (ROOT_W + 1)'(srem_shift - trial) : (ROOT_W + 1)'(srem_shift);
        root_r <= {root_r[ROOT_W-2:0], r_bit};
      end
      step_r <= step_r - STEP_W'(1);
    end
  end

  assign mean_full = neg_r ? (~dvd_r + SUM_W'(1)) : dvd_r;

  assign out_res.minimum          = low_r;
  assign out_res.maximum          = high_r;
  assign out_res.mean             = mean_full[DATA_W-1:0];
  assign out_res.root_sum_squares = root_r;
  assign out_res.item_count       = count_r;
  assign out_res.overflow         = ovf_r;

endmodule

/* hw/rtl/field_statistics_reducer_core.sv */
// A result is offered after the request ending its field passes the front stage register, record
// queue and back end's 41-step serial divider. Throughput: one sample request per cycle while the
// queue has room; the back end takes a new field only once the last result is taken, and a
// two-entry record queue absorbs short fields. The square root steps in the last ROOT_STEPS divider steps.
// Reset (rst_n low at a clock edge, synchronous) empties the pipeline and queue and
// returns the running statistics to their initial values.
`timescale 1ns / 1ps
module field_statistics_reducer_core
  import fsr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  fsr_in_if.sink    in_req,
  fsr_out_if.source out_res
);

  fsr_push_t        push;
  logic             pop;
  logic             q_valid;
  fsr_stats_t       q_data;
  logic [LVL_W-1:0] q_level;

  fsr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .q_level (q_level),
    .push    (push)
  );

  fsr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .pop     (pop),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_level (q_level)
  );

  fsr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .out_res (out_res)
  );

endmodule

/* hw/rtl/fsr_checker.sv */
// Port-level checker of the field statistics reducer and its bind statement.
`timescale 1ns / 1ps
`include "field_statistics_reducer_core_macros.svh"
module fsr_checker
  import fsr_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] minimum,
  input logic signed [DATA_W-1:0] maximum,
  input logic [CNT_W-1:0]         item_count,
  input logic                     overflow
);

  // A result waiting for the sink stays offered.
  `FSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // Every field holds at least one counted sample and never more than the limit.
  `FSR_ASSERT_NOW(a_count_range, out_valid, item_count != '0 && item_count <= CNT_W'(MAX_COUNT))

  // An overflowed field has counted up to the limit.
  `FSR_ASSERT_NOW(a_ovf_full, out_valid && overflow, item_count == CNT_W'(MAX_COUNT))

  `FSR_ASSERT_NOW(a_min_le_max, out_valid, minimum <= maximum)

endmodule

bind field_statistics_reducer_core fsr_checker u_fsr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_res.valid),
  .out_ready  (out_res.ready),
  .minimum    (out_res.minimum),
  .maximum    (out_res.maximum),
  .item_count (out_res.item_count),
  .overflow   (out_res.overflow)
);

/* verif/tb_top.sv */
// Self-checking testbench for the field statistics reducer: directed table, random fields, idling.
`timescale 1ns / 1ps
module tb_top;
  import fsr_pkg::*;

  localparam logic signed [DATA_W-1:0] SMAX = 24'sh7FFFFF;
  localparam logic signed [DATA_W-1:0] SMIN = 24'sh800000;
  // Worst quiet stretch is the HOLD_CYCLES receiver hold-off plus the time one result takes to come out.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 60;
  localparam int PHASE_ITEMS    = 610;
  localparam int ROW_COUNT      = 13;

  typedef struct packed {
    logic signed [DATA_W-1:0] minimum;
    logic signed [DATA_W-1:0] maximum;
    logic signed [DATA_W-1:0] mean;
    logic [ROOT_W-1:0]        root;
    logic [CNT_W-1:0]         count;
    logic                     ovf;
  } field_result_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     last;
    int                       reps;
    logic                     typed;
    field_result_t            want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  fsr_in_if  req_if ();
  fsr_out_if res_if ();

  field_statistics_reducer_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_res (res_if)
  );

  // Rows with a typed-in result are read straight off the definition; the rest use the predictor.
  stim_row_t directed_rows [ROW_COUNT] = '{
    '{24'sd0, 1'b1, 1, 1'b1, '{24'sd0, 24'sd0, 24'sd0, 32'd0, 17'd1, 1'b0}},
    '{SMIN, 1'b1, 1, 1'b1, '{SMIN, SMIN, SMIN, 32'd8388608, 17'd1, 1'b0}},
    '{SMAX, 1'b1, 1, 1'b1, '{SMAX, SMAX, SMAX, 32'd8388607, 17'd1, 1'b0}},
    '{SMAX, 1'b0, 1, 1'b0, '0},
    '{SMIN, 1'b1, 1, 1'b0, '0},
    '{-24'sd3, 1'b0, 1, 1'b0, '0},
    '{-24'sd4, 1'b1, 1, 1'b1, '{-24'sd4, -24'sd3, -24'sd3, 32'd5, 17'd2, 1'b0}},
    '{24'sh555555, 1'b0, 1, 1'b0, '0},
    '{24'shAAAAAA, 1'b0, 1, 1'b0, '0},
    '{24'sd1, 1'b0, 1, 1'b0, '0},
    '{-24'sd1, 1'b1, 1, 1'b0, '0},
    '{24'sd7, 1'b0, 3, 1'b0, '0},
    '{24'sd100, 1'b1, 1, 1'b0, '0}
  };

  // Running statistics of the field that the predictor is folding.
  logic signed [DATA_W-1:0] run_low;
  logic signed [DATA_W-1:0] run_high;
  logic signed [SUM_W-1:0]  run_sum;
  logic [SQ_W-1:0]          run_sq;
  logic [CNT_W-1:0]         run_count;
  logic                     run_ovf;

  field_result_t expected_fields [$];

  int src_idle_pct;
  int sink_idle_pct;
  int hold_left;
  int quiet_cycles;
  int mismatches;
  int fields_checked;
  int overflow_fields;
  int samples_sent;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [ROOT_W-1:0] floor_root(input logic [SQ_W-1:0] n);
    logic [ROOT_W-1:0] r;
    logic [ROOT_W-1:0] trial;
    logic [63:0]       sq;
    r = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = r | (ROOT_W'(1) << b);
      sq = 64'(trial) * 64'(trial);
      if (sq <= 64'(n)) r = trial;
    end
    return r;
  endfunction

  function automatic void clear_field_stats();
    run_low   = SMAX;
    run_high  = SMIN;
    run_sum   = '0;
    run_sq    = '0;
    run_count = '0;
    run_ovf   = 1'b0;
  endfunction

  // Folds one accepted sample; returns 1 with the field's result when the sample ends it.
  function automatic bit fold_sample(input logic signed [DATA_W-1:0] s, input logic is_last,
                                     output field_result_t res);
    longint sl;
    longint quotient;
    sl = s;
    res = '0;
    if (run_count >= CNT_W'(MAX_COUNT)) begin
      run_ovf = 1'b1;
    end else begin
      if (s < run_low) run_low = s;
      if (s > run_high) run_high = s;
      run_sum = run_sum + SUM_W'(sl);
      run_sq = run_sq + SQ_W'(sl * sl);
      run_count = run_count + 1'b1;
    end
    if (!is_last) return 1'b0;
    quotient = longint'(run_sum) / longint'(run_count);
    res.minimum = run_low;
    res.maximum = run_high;
    res.mean    = DATA_W'(quotient);
    res.root    = floor_root(run_sq);
    res.count   = run_count;
    res.ovf     = run_ovf;
    clear_field_stats();
    return 1'b1;
  endfunction

  task automatic send_sample(input logic signed [DATA_W-1:0] s, input logic l,
                             input logic typed, input field_result_t want);
    field_result_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid  = 1'b1;
    req_if.sample = s;
    req_if.last   = l;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    samples_sent++;
    if (fold_sample(s, l, predicted)) begin
      if (typed) expected_fields.push_back(want);
      else expected_fields.push_back(predicted);
    end
  endtask

  function automatic logic signed [DATA_W-1:0] random_sample();
    int pick;
    pick = $urandom_range(9);
    case (pick)
      0: return SMIN;
      1: return SMAX;
      2, 3, 4: return DATA_W'($urandom_range(64) - 32);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic send_random_fields(input int n_items);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 60) len = $urandom_range(4, 1);
      else if (pick < 92) len = $urandom_range(24, 5);
      else len = $urandom_range(160, 25);
      for (int i = 0; i < len; i++) begin
        send_sample(random_sample(), i == len - 1, 1'b0, '0);
      end
      sent += len;
    end
  endtask

  // The sender withdraws its last request before waiting, so it is not taken twice.
  task automatic wait_for_results();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (expected_fields.size() > 0) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input logic [ROOT_W-1:0] want,
                                      input logic [ROOT_W-1:0] got, inout bit bad);
    if (want !== got) begin
      bad = 1'b1;
      if (mismatches < 10) begin
        $display("mismatch in field %0d, %s: expected %0h, got %0h",
                 fields_checked, name, want, got);
      end
    end
  endfunction

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_if.ready = 1'b0;
      hold_left--;
    end else begin
      res_if.ready = rst_n && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    field_result_t want;
    bit bad;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_fields.size() == 0) begin
        if (mismatches < 10) $display("result arrived with no field pending");
        mismatches++;
      end else begin
        want = expected_fields.pop_front();
        bad = 1'b0;
        check_field("minimum", ROOT_W'(want.minimum), ROOT_W'(res_if.minimum), bad);
        check_field("maximum", ROOT_W'(want.maximum), ROOT_W'(res_if.maximum), bad);
        check_field("mean", ROOT_W'(want.mean), ROOT_W'(res_if.mean), bad);
        check_field("root_sum_squares", want.root, res_if.root_sum_squares, bad);
        check_field("item_count", ROOT_W'(want.count), ROOT_W'(res_if.item_count), bad);
        check_field("overflow", ROOT_W'(want.ovf), ROOT_W'(res_if.overflow), bad);
        if (bad) mismatches++;
        if (want.ovf) overflow_fields++;
        fields_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles, %0d results outstanding",
               quiet_cycles, expected_fields.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.sample = '0;
    req_if.last = 1'b0;
    res_if.ready = 1'b0;
    src_idle_pct = 22;
    sink_idle_pct = 46;
    hold_left = 0;
    quiet_cycles = 0;
    mismatches = 0;
    fields_checked = 0;
    overflow_fields = 0;
    samples_sent = 0;
    clear_field_stats();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < ROW_COUNT; r++) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        send_sample(directed_rows[r].sample,
                    directed_rows[r].last && (k == directed_rows[r].reps - 1),
                    directed_rows[r].typed, directed_rows[r].want);
      end
    end
    send_random_fields(PHASE_ITEMS);
    wait_for_results();

    src_idle_pct = 46;
    sink_idle_pct = 22;
    send_random_fields(PHASE_ITEMS);
    wait_for_results();

    src_idle_pct = 0;
    sink_idle_pct = 0;
    // Single-sample fields pile up behind the held-off receiver until the input stalls.
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 24; i++) send_sample(random_sample(), 1'b1, 1'b0, '0);
    send_random_fields(PHASE_ITEMS);
    @(negedge clk);
    req_if.valid = 1'b0;
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d samples in %0d fields, %0d of them past the count limit",
             samples_sent, fields_checked, overflow_fields);
    $display("idling: sender-heavy, receiver-heavy, none; one long receiver hold-off");
    if (mismatches == 0 && expected_fields.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_fields.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/fsr_pkg.sv
hw/rtl/fsr_if.sv
hw/rtl/fsr_front.sv
hw/rtl/fsr_queue.sv
hw/rtl/fsr_back.sv
hw/rtl/field_statistics_reducer_core.sv
hw/rtl/fsr_checker.sv
verif/tb_top.sv
